// File: src/nfcs_pkg.sv
package nfcs_pkg;

    localparam int unsigned FIELD_ADDR_W = 19;
    localparam int unsigned DATA_W       = 16;
    localparam int unsigned TICKS_W      = 16;

    // request codes
    localparam logic [2:0] MODE_READ         = 3'd0;
    localparam logic [2:0] MODE_PROGRAM      = 3'd1;
    localparam logic [2:0] MODE_SECTOR_ERASE = 3'd2;
    localparam logic [2:0] MODE_CHIP_ERASE   = 3'd3;
    localparam logic [2:0] MODE_READ_ID      = 3'd4;
    localparam logic [2:0] MODE_RESET        = 3'd5;
    localparam logic [2:0] MODE_TICK         = 3'd6;

    // result cycle kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_BUSY    = 2'd2;

    // flash command words and unlock addresses
    localparam logic [DATA_W-1:0] CMD_UNLOCK1  = 16'h00AA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2  = 16'h0055;
    localparam logic [DATA_W-1:0] CMD_AUTOSEL  = 16'h0090;
    localparam logic [DATA_W-1:0] CMD_ERASE    = 16'h0080;
    localparam logic [DATA_W-1:0] CMD_CHIP     = 16'h0010;
    localparam logic [DATA_W-1:0] CMD_SECTOR   = 16'h0030;
    localparam logic [DATA_W-1:0] CMD_PROGRAM  = 16'h00A0;
    localparam logic [DATA_W-1:0] CMD_RESET    = 16'h00F0;
    localparam logic [DATA_W-1:0] DATA_NONE    = 16'h0000;

    localparam logic [FIELD_ADDR_W-1:0] UNLOCK_A1 = 19'h00555;
    localparam logic [FIELD_ADDR_W-1:0] UNLOCK_A2 = 19'h002AA;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd5000;

    // job queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // sequence step counter, longest sequence has six bus cycles
    localparam int unsigned STEP_W   = 3;
    localparam logic [STEP_W-1:0] MAX_STEP = 3'd5;

    typedef struct packed {
        logic [2:0]              mode;
        logic [FIELD_ADDR_W-1:0] flash_addr;
        logic [DATA_W-1:0]       prog_word;
        logic                    ready_pin;
        logic                    final_word;
    } req_t;

    typedef struct packed {
        logic [1:0]              cycle_kind;
        logic [FIELD_ADDR_W-1:0] bus_addr;
        logic [DATA_W-1:0]       bus_data;
        logic [1:0]              status;
        logic                    release_bus;
        logic                    last;
    } rsp_t;

    typedef enum logic [2:0] {
        JOB_READ         = 3'd0,
        JOB_PROGRAM      = 3'd1,
        JOB_SECTOR_ERASE = 3'd2,
        JOB_CHIP_ERASE   = 3'd3,
        JOB_READ_ID      = 3'd4,
        JOB_RESET        = 3'd5,
        JOB_STATUS       = 3'd6,
        JOB_TIMEOUT      = 3'd7
    } job_kind_t;

    typedef struct packed {
        job_kind_t               kind;
        logic [FIELD_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]       data;
        logic [1:0]              status;
        logic                    rel;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    typedef enum logic [2:0] {
        ASEL_JOB     = 3'd0,
        ASEL_ZERO    = 3'd1,
        ASEL_ONE     = 3'd2,
        ASEL_UNLOCK1 = 3'd3,
        ASEL_UNLOCK2 = 3'd4
    } addr_sel_t;

    typedef struct packed {
        logic [1:0]        cycle_kind;
        addr_sel_t         addr_sel;
        logic              use_job_data;
        logic [DATA_W-1:0] cmd;
        logic [1:0]        status;
        logic              rel;
        logic              last;
    } seq_t;

    function automatic seq_t seq_write(addr_sel_t sel, logic [DATA_W-1:0] cmd,
                                       logic rel, logic last);
        seq_t s;
        s.cycle_kind   = KIND_WRITE;
        s.addr_sel     = sel;
        s.use_job_data = 1'b0;
        s.cmd          = cmd;
        s.status       = STAT_OK;
        s.rel          = rel;
        s.last         = last;
        return s;
    endfunction

    function automatic seq_t seq_read(addr_sel_t sel, logic rel, logic last);
        seq_t s;
        s.cycle_kind   = KIND_READ;
        s.addr_sel     = sel;
        s.use_job_data = 1'b0;
        s.cmd          = DATA_NONE;
        s.status       = STAT_OK;
        s.rel          = rel;
        s.last         = last;
        return s;
    endfunction

    // One bus cycle of a job's sequence, chosen by job kind and step.
    function automatic seq_t seq_decode(job_kind_t kind, logic [STEP_W-1:0] step,
                                        logic job_rel, logic [1:0] job_status);
        seq_t s;
        s = seq_write(ASEL_ZERO, CMD_RESET, 1'b1, 1'b1);
        case (kind)
            JOB_READ:
            begin
                s = seq_read(ASEL_JOB, job_rel, 1'b1);
            end
            JOB_PROGRAM:
            begin
                case (step)
                    3'd0:    s = seq_write(ASEL_UNLOCK1, CMD_UNLOCK1, 1'b0, 1'b0);
                    3'd1:    s = seq_write(ASEL_UNLOCK2, CMD_UNLOCK2, 1'b0, 1'b0);
                    3'd2:    s = seq_write(ASEL_UNLOCK1, CMD_PROGRAM, 1'b0, 1'b0);
                    default:
                    begin
                        s = seq_write(ASEL_JOB, DATA_NONE, 1'b0, 1'b1);
                        s.use_job_data = 1'b1;
                    end
                endcase
            end
            JOB_SECTOR_ERASE, JOB_CHIP_ERASE:
            begin
                case (step)
                    3'd0:    s = seq_write(ASEL_UNLOCK1, CMD_UNLOCK1, 1'b0, 1'b0);
                    3'd1:    s = seq_write(ASEL_UNLOCK2, CMD_UNLOCK2, 1'b0, 1'b0);
                    3'd2:    s = seq_write(ASEL_UNLOCK1, CMD_ERASE, 1'b0, 1'b0);
                    3'd3:    s = seq_write(ASEL_UNLOCK1, CMD_UNLOCK1, 1'b0, 1'b0);
                    3'd4:    s = seq_write(ASEL_UNLOCK2, CMD_UNLOCK2, 1'b0, 1'b0);
                    default:
                    begin
                        if (kind == JOB_SECTOR_ERASE)
                        begin
                            s = seq_write(ASEL_JOB, CMD_SECTOR, 1'b1, 1'b1);
                        end
                        else
                        begin
                            s = seq_write(ASEL_UNLOCK1, CMD_CHIP, 1'b1, 1'b1);
                        end
                    end
                endcase
            end
            JOB_READ_ID:
            begin
                case (step)
                    3'd0:    s = seq_write(ASEL_UNLOCK1, CMD_UNLOCK1, 1'b0, 1'b0);
                    3'd1:    s = seq_write(ASEL_UNLOCK2, CMD_UNLOCK2, 1'b0, 1'b0);
                    3'd2:    s = seq_write(ASEL_UNLOCK1, CMD_AUTOSEL, 1'b0, 1'b0);
                    3'd3:    s = seq_read(ASEL_ZERO, 1'b0, 1'b0);
                    3'd4:    s = seq_read(ASEL_ONE, 1'b0, 1'b0);
                    default: s = seq_write(ASEL_ZERO, CMD_RESET, 1'b1, 1'b1);
                endcase
            end
            JOB_STATUS:
            begin
                s.cycle_kind = KIND_STATUS;
                s.addr_sel   = ASEL_ZERO;
                s.cmd        = DATA_NONE;
                s.status     = job_status;
                s.rel        = job_rel;
            end
            JOB_TIMEOUT:
            begin
                s.status = STAT_TIMEOUT;
            end
            default:
            begin
                s = seq_write(ASEL_ZERO, CMD_RESET, 1'b1, 1'b1);
            end
        endcase
        return s;
    endfunction

endpackage

// File: src/nfcs_if.sv
interface nfcs_req_if;
    import nfcs_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface nfcs_rsp_if;
    import nfcs_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface nfcs_cfg_if;
    import nfcs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TICKS_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/nfcs_front.sv
module nfcs_front (
    input  logic            clk,
    input  logic            rst_n,
    nfcs_req_if.sink        req,
    nfcs_cfg_if.sink        cfg,
    input  logic            queue_full,
    output nfcs_pkg::push_t push
);
    import nfcs_pkg::*;

    logic [TICKS_W-1:0] timeout_reg;
    logic               waiting_reg;
    logic               waiting_next;
    logic [TICKS_W-1:0] count_reg;
    logic [TICKS_W-1:0] count_next;
    logic               burst_final_reg;
    logic               burst_final_next;
    logic               accept;
    logic               want_push;
    job_t               job;

    assign req.ready = !queue_full;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        want_push        = 1'b0;
        job.kind         = JOB_STATUS;
        job.addr         = req.payload.flash_addr;
        job.data         = req.payload.prog_word;
        job.status       = STAT_OK;
        job.rel          = 1'b0;
        waiting_next     = waiting_reg;
        count_next       = count_reg;
        burst_final_next = burst_final_reg;
        case (req.payload.mode)
            MODE_TICK:
            begin
                if (!waiting_reg)
                begin
                    want_push = 1'b1;
                end
                else if (req.payload.ready_pin)
                begin
                    want_push    = 1'b1;
                    job.rel      = burst_final_reg;
                    waiting_next = 1'b0;
                end
                else if (count_reg <= 16'd1)
                begin
                    want_push    = 1'b1;
                    job.kind     = JOB_TIMEOUT;
                    waiting_next = 1'b0;
                    count_next   = '0;
                end
                else
                begin
                    count_next = count_reg - 16'd1;
                end
            end
            MODE_READ, MODE_PROGRAM, MODE_SECTOR_ERASE, MODE_CHIP_ERASE,
            MODE_READ_ID, MODE_RESET:
            begin
                want_push = 1'b1;
                if (waiting_reg)
                begin
                    job.status = STAT_BUSY;
                end
                else
                begin
                    case (req.payload.mode)
                        MODE_READ:
                        begin
                            job.kind = JOB_READ;
                            job.rel  = req.payload.final_word;
                        end
                        MODE_PROGRAM:
                        begin
                            job.kind         = JOB_PROGRAM;
                            waiting_next     = 1'b1;
                            count_next       = timeout_reg;
                            burst_final_next = req.payload.final_word;
                        end
                        MODE_SECTOR_ERASE: job.kind = JOB_SECTOR_ERASE;
                        MODE_CHIP_ERASE:   job.kind = JOB_CHIP_ERASE;
                        MODE_READ_ID:      job.kind = JOB_READ_ID;
                        default:           job.kind = JOB_RESET;
                    endcase
                end
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    assign push.valid = accept && want_push;
    assign push.job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            waiting_reg     <= 1'b0;
            count_reg       <= '0;
            burst_final_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.data;
            end
            if (accept)
            begin
                waiting_reg     <= waiting_next;
                count_reg       <= count_next;
                burst_final_reg <= burst_final_next;
            end
        end
    end

    a_program_starts_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !waiting_reg && req.payload.mode == MODE_PROGRAM) |=> waiting_reg)
        else $error("program accepted while idle did not start the ready wait");

endmodule

// File: src/nfcs_queue.sv
module nfcs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  nfcs_pkg::push_t push,
    output logic            full,
    output nfcs_pkg::head_t head,
    input  logic            pop
);
    import nfcs_pkg::*;

    job_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = slots_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;
    assign count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("job popped from an empty queue");

endmodule

// File: src/nfcs_back.sv
module nfcs_back #(
    parameter int unsigned ADDR_BITS = 19
) (
    input  logic            clk,
    input  logic            rst_n,
    input  nfcs_pkg::head_t head,
    output logic            pop,
    nfcs_rsp_if.source      rsp
);
    import nfcs_pkg::*;

    localparam int unsigned KEEP_W = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
    localparam logic [FIELD_ADDR_W-1:0] ADDR_MASK =
        FIELD_ADDR_W'((64'd1 << KEEP_W) - 64'd1);

    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    rsp_t                    rsp_data_reg;
    rsp_t                    rsp_data_next;
    logic                    load;
    seq_t                    seq;
    logic [FIELD_ADDR_W-1:0] sel_addr;

    assign load = head.valid && (!rsp_valid_reg || rsp.ready);
    assign seq  = seq_decode(head.job.kind, step_reg, head.job.rel, head.job.status);
    assign pop  = load && seq.last;

    always_comb
    begin
        case (seq.addr_sel)
            ASEL_JOB:     sel_addr = head.job.addr;
            ASEL_ONE:     sel_addr = FIELD_ADDR_W'(1);
            ASEL_UNLOCK1: sel_addr = UNLOCK_A1;
            ASEL_UNLOCK2: sel_addr = UNLOCK_A2;
            default:      sel_addr = '0;
        endcase
    end

    always_comb
    begin
        rsp_data_next.cycle_kind  = seq.cycle_kind;
        rsp_data_next.bus_addr    = sel_addr & ADDR_MASK;
        rsp_data_next.bus_data    = seq.use_job_data ? head.job.data : seq.cmd;
        rsp_data_next.status      = seq.status;
        rsp_data_next.release_bus = seq.rel;
        rsp_data_next.last        = seq.last;

        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            step_next      = seq.last ? '0 : step_reg + STEP_W'(1);
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= MAX_STEP)
        else $error("sequence step beyond the longest command sequence");

    a_step_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (step_reg == '0))
        else $error("step counter not cleared after the last bus cycle of a job");

endmodule

// File: src/nor_flash_command_sequencer_unit.sv
// Channel  Dir   Payload                                              Transfer when
// -------  ----  ---------------------------------------------------  ----------------------
// cfg      in    data: program_timeout_ticks (16 bit)                 cfg.valid & cfg.ready
// req      in    mode, flash_addr, prog_word, ready_pin, final_word   req.valid & req.ready
// rsp      out   cycle_kind, bus_addr, bus_data, status,              rsp.valid & rsp.ready
//                release_bus, last
//
// Each request yields 0 to 6 results, one per bus cycle; the back end sends one result
// per clock while rsp.ready does not stall its output register.
// The front end takes one request per clock while the four-entry job queue has room;
// the wait state (program wait, tick countdown) is updated at the transfer itself.
// A stalled rsp holds its output register; the queue then fills and req.ready drops.
// Reset (rst_n low, asynchronous) empties the queue, clears the wait and loads the
// timeout register with 5000. cfg.ready is always high.
module nor_flash_command_sequencer_unit #(
    parameter int unsigned ADDR_BITS = 19
) (
    input  logic       clk,
    input  logic       rst_n,
    nfcs_cfg_if.sink   cfg,
    nfcs_req_if.sink   req,
    nfcs_rsp_if.source rsp
);
    import nfcs_pkg::*;

    push_t push;
    head_t head;
    logic  queue_full;
    logic  pop;

    // Front end: classify each request, track the program wait, push one job per
    // request that produces results.
    nfcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push)
    );

    // Hold pending jobs so the front end keeps accepting while the bus side stalls.
    nfcs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    // Back end: step through the head job's bus cycles, advance on each output
    // transfer slot, drop the job after its last cycle.
    nfcs_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
